/* rtl/ftb_pkg.sv */
// Shared constants and types for the fraction-to-boundary step block.
package ftb_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Default safety margin, given in Q0.16 and rescaled to the fraction width in use.
	localparam int MARGIN_RESET_Q16 = 65208;

	typedef struct packed {
		logic done;
		logic ok;
	} ftb_status_t;

endpackage

/* rtl/ftb_serial_div.sv */
// Bit-serial margin multiplier and restoring divider forming one candidate fraction.
module ftb_serial_div #(
	parameter int VALUE_WIDTH = ftb_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = ftb_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [FRAC_BITS:0]       margin,
	input  logic [VALUE_WIDTH-1:0]   vmag,
	input  logic [VALUE_WIDTH-1:0]   dmag,
	output ftb_pkg::ftb_status_t     status,
	output logic [FRAC_BITS-1:0]     quotient
);
	import ftb_pkg::*;

	localparam int W     = VALUE_WIDTH + FRAC_BITS + 1;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_MUL  = 3'b010,
		C_DIV  = 3'b100
	} core_state_t;

	core_state_t          state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic                 ok_q;
	logic [W-1:0]         acc_q;
	logic [W-1:0]         mcand_q;
	logic [FRAC_BITS:0]   mplier_q;
	logic [W-1:0]         dsr_q;
	logic [FRAC_BITS-1:0] q_q;
	logic                 ge;
	logic [W-1:0]         diff;
	logic                 top_step;

	assign ge       = (acc_q >= dsr_q);
	assign diff     = acc_q - dsr_q;
	assign top_step = (cnt_q == CNT_W'(FRAC_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_MUL;
					end
				end
				C_MUL: begin
					if (mplier_q == '0) begin
						cnt_q   <= CNT_W'(FRAC_BITS);
						state_q <= C_DIV;
					end
				end
				C_DIV: begin
					if (top_step) begin
						if (ge) begin
							done_q  <= 1'b1;
							ok_q    <= 1'b0;
							state_q <= C_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end else if (cnt_q == '0) begin
						done_q  <= 1'b1;
						ok_q    <= 1'b1;
						state_q <= C_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					acc_q    <= '0;
					mcand_q  <= W'(vmag);
					mplier_q <= margin;
					dsr_q    <= W'(dmag) << FRAC_BITS;
				end
			end
			C_MUL: begin
				if (mplier_q != '0) begin
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			C_DIV: begin
				if (ge) begin
					acc_q <= diff;
				end
				dsr_q <= dsr_q >> 1;
				if (!top_step) begin
					q_q <= {q_q[FRAC_BITS-2:0], ge};
				end
			end
			default: begin
			end
		endcase
	end

	assign status.done = done_q;
	assign status.ok   = ok_q;
	assign quotient    = q_q;

endmodule

/* rtl/fraction_to_boundary_step_top.sv */
// Top level of the fraction-to-boundary step block: handshakes, running minimum, result register.
//
// Each item carries a value and its search direction; the block keeps the smallest admissible
// fraction tau*|value|/|direction| below 1.0 and delivers it, then restarts at 1.0, on the item
// marked last. An item whose direction is zero, whose value is zero or whose signs agree skips
// the datapath. Any other item goes through a shared bit-serial datapath: it is accepted, then
// multiplied by margin_rate one bit at a time up to the highest set bit, then divided in steps
// of one quotient bit each after a first step that rejects a fraction of 1.0 or more, and the
// result is folded into the running minimum. A last item then passes through ST_EMIT, which
// loads the result register. New items are taken only while the datapath is free.
module fraction_to_boundary_step_top #(
	parameter int VALUE_WIDTH = ftb_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = ftb_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [FRAC_BITS:0]            cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic signed [VALUE_WIDTH-1:0] direction,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [FRAC_BITS:0]            step_size
);
	import ftb_pkg::*;

	localparam int NW = FRAC_BITS + 1;
	localparam logic [NW-1:0] ONE_RAW = NW'(1) << FRAC_BITS;
	localparam longint MARGIN_RESET_L = (FRAC_BITS >= 16)
		? (longint'(MARGIN_RESET_Q16) << (FRAC_BITS - 16))
		: (longint'(MARGIN_RESET_Q16) >> (16 - FRAC_BITS));
	localparam logic [NW-1:0] MARGIN_RESET = NW'(MARGIN_RESET_L);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} top_state_t;

	top_state_t             state_q;
	logic [NW-1:0]          margin_rate_q;
	logic [NW-1:0]          running_min_q;
	logic                   last_q;
	logic                   out_valid_q;
	logic [NW-1:0]          step_size_q;
	logic                   in_accept;
	logic                   vneg;
	logic                   dneg;
	logic [VALUE_WIDTH-1:0] vmag;
	logic [VALUE_WIDTH-1:0] dmag;
	logic                   eligible;
	logic                   start;
	logic                   out_free;
	ftb_status_t            core_status;
	logic [FRAC_BITS-1:0]   quotient;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign vneg = value[VALUE_WIDTH-1];
	assign dneg = direction[VALUE_WIDTH-1];
	assign vmag = vneg ? (~value + 1'b1) : value;
	assign dmag = dneg ? (~direction + 1'b1) : direction;

	assign eligible = (vmag != '0) && (dmag != '0) && (vneg != dneg);
	assign start    = in_accept && eligible;
	assign out_free = !out_valid_q || !out_stall;

	ftb_serial_div #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.margin  (margin_rate_q),
		.vmag    (vmag),
		.dmag    (dmag),
		.status  (core_status),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			margin_rate_q <= MARGIN_RESET;
			running_min_q <= ONE_RAW;
			last_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				margin_rate_q <= cfg_wdata;
			end
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						last_q <= last;
						if (eligible) begin
							state_q <= ST_RUN;
						end else if (last) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_RUN: begin
					if (core_status.done) begin
						if (core_status.ok && (quotient != '0)
						    && ({1'b0, quotient} < running_min_q)) begin
							running_min_q <= {1'b0, quotient};
						end
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						running_min_q <= ONE_RAW;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			step_size_q <= running_min_q;
		end
	end

	assign out_valid = out_valid_q;
	assign step_size = step_size_q;

endmodule
